// File: rtl/core/assert_macros.svh
// Assertion macros shared by the mixer RTL.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSMGR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define SSMGR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: rtl/core/ssmgr_pkg.sv
// Shared types and constants for the stereo mixer with gain ramp.
// No dependencies.
package ssmgr_pkg;

  localparam int CHUNK_FRAMES_DEF = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCENT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAN         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_START  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_START = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_STEP  = 3'd7;

  localparam logic [1:0] MODE_ACCENT = 2'd1;

  localparam logic [8:0]  LEVEL_MAX   = 9'd256;
  localparam logic [20:0] GAIN_MAX    = 21'd4095;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_PPL,
    S_GL,
    S_PPR,
    S_GR,
    S_MIXLG,
    S_MIXL,
    S_MIXR,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_BASE,
    MUL_PPL,
    MUL_GL,
    MUL_PPR,
    MUL_GR,
    MUL_MIXL,
    MUL_MIXR
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     clamp;
    logic     load_base;
    logic     load_gain_l;
    logic     load_gain_r;
    logic     load_mix_l;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic chunk_start;
  } status_t;

endpackage

// File: rtl/core/ssmgr_ctrl.sv
// Sequencer for the mixer: steps the shared multiplier and the output handshake.
// Depends on ssmgr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssmgr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ssmgr_pkg::status_t status,
  output ssmgr_pkg::cmd_t    cmd
);

  ssmgr_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ssmgr_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ssmgr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = status.chunk_start ? ssmgr_pkg::S_BASE : ssmgr_pkg::S_MIXL;
        end
      end
      ssmgr_pkg::S_BASE:  state_next = ssmgr_pkg::S_PPL;
      ssmgr_pkg::S_PPL:   state_next = ssmgr_pkg::S_GL;
      ssmgr_pkg::S_GL:    state_next = ssmgr_pkg::S_PPR;
      ssmgr_pkg::S_PPR:   state_next = ssmgr_pkg::S_GR;
      ssmgr_pkg::S_GR:    state_next = ssmgr_pkg::S_MIXLG;
      ssmgr_pkg::S_MIXLG: state_next = ssmgr_pkg::S_MIXR;
      ssmgr_pkg::S_MIXL:  state_next = ssmgr_pkg::S_MIXR;
      ssmgr_pkg::S_MIXR:  state_next = ssmgr_pkg::S_DONE;
      ssmgr_pkg::S_DONE: begin
        if (out_free) begin
          state_next = ssmgr_pkg::S_IDLE;
        end
      end
      default: state_next = ssmgr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_sel = ssmgr_pkg::MUL_BASE;
    in_ready = 1'b0;
    case (state)
      ssmgr_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ssmgr_pkg::S_BASE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ssmgr_pkg::MUL_BASE;
        cmd.clamp   = 1'b1;
      end
      ssmgr_pkg::S_PPL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = ssmgr_pkg::MUL_PPL;
        cmd.load_base = 1'b1;
      end
      ssmgr_pkg::S_GL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ssmgr_pkg::MUL_GL;
      end
      ssmgr_pkg::S_PPR: begin
        cmd.mul_en      = 1'b1;
        cmd.mul_sel     = ssmgr_pkg::MUL_PPR;
        cmd.load_gain_l = 1'b1;
      end
      ssmgr_pkg::S_GR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ssmgr_pkg::MUL_GR;
      end
      ssmgr_pkg::S_MIXLG: begin
        cmd.mul_en      = 1'b1;
        cmd.mul_sel     = ssmgr_pkg::MUL_MIXL;
        cmd.load_gain_r = 1'b1;
      end
      ssmgr_pkg::S_MIXL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ssmgr_pkg::MUL_MIXL;
      end
      ssmgr_pkg::S_MIXR: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = ssmgr_pkg::MUL_MIXR;
        cmd.load_mix_l = 1'b1;
      end
      ssmgr_pkg::S_DONE: begin
        cmd.finish = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // an accepted beat always starts work
  `SSMGR_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
  // results only land in a free output register
  `SSMGR_ASSERT_IMP(a_finish_free, clk, rst, cmd.finish, !out_valid || out_ready)
  // finishing presents a result and returns to idle
  `SSMGR_ASSERT_NXT(a_finish_idle, clk, rst, cmd.finish,
                    out_valid && state == ssmgr_pkg::S_IDLE)
  // at most one gain or base register loads per cycle
  `SSMGR_ASSERT_IMP(a_load_onehot, clk, rst, 1'b1,
                    $onehot0({cmd.load_base, cmd.load_gain_l, cmd.load_gain_r}))

endmodule

// File: rtl/core/ssmgr_datapath.sv
// Datapath: config registers, level ramp, chunk counter, shared multiplier, mix.
// Depends on ssmgr_pkg.
module ssmgr_datapath #(
  parameter int CHUNK_FRAMES = ssmgr_pkg::CHUNK_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ssmgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssmgr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             note_first,
  input  logic signed [15:0]               src_left,
  input  logic signed [15:0]               src_right,
  input  logic signed [31:0]               mix_left_in,
  input  logic signed [31:0]               mix_right_in,
  output logic signed [31:0]               mix_left_out,
  output logic signed [31:0]               mix_right_out,
  input  ssmgr_pkg::cmd_t                  cmd,
  output ssmgr_pkg::status_t               status
);

  localparam int CW = (CHUNK_FRAMES > 1) ? $clog2(CHUNK_FRAMES) : 1;
  localparam logic [CW-1:0] CHUNK_LAST = CW'(CHUNK_FRAMES - 1);
  localparam logic [31:0]   CHUNK_MUL  = 32'(CHUNK_FRAMES);

  // config
  logic [1:0]         play_mode;
  logic [8:0]         base_level;
  logic [9:0]         accent_level;
  logic [8:0]         pan_position;
  logic [24:0]        left_start;
  logic signed [17:0] left_step;
  logic [24:0]        right_start;
  logic signed [17:0] right_step;

  // state
  logic [CW-1:0] chunk_count;
  logic [31:0]   left_ext;
  logic [31:0]   right_ext;
  logic [11:0]   left_gain;
  logic [11:0]   right_gain;

  // working registers
  logic signed [15:0] smp_l, smp_r;
  logic signed [31:0] acc_l, acc_r;
  logic signed [35:0] prod;
  logic [9:0]         base_r;
  logic signed [31:0] mix_l;

  logic [8:0]         lvl_sat, pan_sat;
  logic [9:0]         base_now;
  logic signed [18:0] mul_a;
  logic signed [16:0] mul_b;
  logic [20:0]        gain_q;
  logic [11:0]        gain_sat;
  logic signed [31:0] scaled;
  logic               mute;
  logic [31:0]        left_adv, right_adv;

  assign mute     = play_mode[1];
  assign lvl_sat  = (base_level > ssmgr_pkg::LEVEL_MAX) ? ssmgr_pkg::LEVEL_MAX : base_level;
  assign pan_sat  = (pan_position > ssmgr_pkg::LEVEL_MAX) ? ssmgr_pkg::LEVEL_MAX
                                                           : pan_position;
  assign base_now = (play_mode == ssmgr_pkg::MODE_ACCENT) ? prod[17:8] : {1'b0, lvl_sat};

  assign gain_q   = prod[35:15];
  assign gain_sat = (gain_q > ssmgr_pkg::GAIN_MAX) ? 12'hFFF : gain_q[11:0];
  // low 32 bits of the product, arithmetic shift by 8
  assign scaled   = {{8{prod[31]}}, prod[31:8]};

  assign left_adv  = left_ext + {{14{left_step[17]}}, left_step} * CHUNK_MUL;
  assign right_adv = right_ext + {{14{right_step[17]}}, right_step} * CHUNK_MUL;

  assign status.chunk_start = note_first || (chunk_count == '0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      ssmgr_pkg::MUL_BASE: begin
        mul_a = {9'd0, accent_level};
        mul_b = {8'd0, lvl_sat};
      end
      ssmgr_pkg::MUL_PPL: begin
        mul_a = {10'd0, ssmgr_pkg::LEVEL_MAX - pan_sat};
        mul_b = {7'd0, base_now};
      end
      ssmgr_pkg::MUL_GL: begin
        mul_a = {1'b0, prod[17:0]};
        mul_b = {2'd0, left_ext[30:16]};
      end
      ssmgr_pkg::MUL_PPR: begin
        mul_a = {10'd0, pan_sat};
        mul_b = {7'd0, base_r};
      end
      ssmgr_pkg::MUL_GR: begin
        mul_a = {1'b0, prod[17:0]};
        mul_b = {2'd0, right_ext[30:16]};
      end
      ssmgr_pkg::MUL_MIXL: begin
        mul_a = {{3{smp_l[15]}}, smp_l};
        mul_b = {5'd0, left_gain};
      end
      ssmgr_pkg::MUL_MIXR: begin
        mul_a = {{3{smp_r[15]}}, smp_r};
        mul_b = {5'd0, right_gain};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode    <= '0;
      base_level   <= 9'd128;
      accent_level <= 10'd384;
      pan_position <= 9'd128;
      left_start   <= '0;
      left_step    <= '0;
      right_start  <= '0;
      right_step   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssmgr_pkg::REG_PLAY_MODE:   play_mode    <= cfg_data[1:0];
        ssmgr_pkg::REG_BASE_LEVEL:  base_level   <= cfg_data[8:0];
        ssmgr_pkg::REG_ACCENT:      accent_level <= cfg_data[9:0];
        ssmgr_pkg::REG_PAN:         pan_position <= cfg_data[8:0];
        ssmgr_pkg::REG_LEFT_START:  left_start   <= cfg_data[24:0];
        ssmgr_pkg::REG_LEFT_STEP:   left_step    <= cfg_data[17:0];
        ssmgr_pkg::REG_RIGHT_START: right_start  <= cfg_data[24:0];
        ssmgr_pkg::REG_RIGHT_STEP:  right_step   <= cfg_data[17:0];
        default: begin
          play_mode <= play_mode;
        end
      endcase
    end
  end

  // ramp state and gains
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count <= '0;
      left_ext    <= '0;
      right_ext   <= '0;
      left_gain   <= '0;
      right_gain  <= '0;
    end else begin
      if (cmd.accept && note_first) begin
        chunk_count <= '0;
        left_ext    <= {7'd0, left_start};
        right_ext   <= {7'd0, right_start};
      end else if (cmd.clamp) begin
        if (left_ext[31]) left_ext <= '0;
        if (right_ext[31]) right_ext <= '0;
      end else if (cmd.finish) begin
        if (chunk_count == CHUNK_LAST) begin
          chunk_count <= '0;
          left_ext    <= left_adv;
          right_ext   <= right_adv;
        end else begin
          chunk_count <= chunk_count + CW'(1);
        end
      end
      if (cmd.load_gain_l) left_gain <= gain_sat;
      if (cmd.load_gain_r) right_gain <= gain_sat;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_l <= src_left;
      smp_r <= src_right;
      acc_l <= mix_left_in;
      acc_r <= mix_right_in;
    end
    if (cmd.mul_en) prod <= mul_a * mul_b;
    if (cmd.load_base) base_r <= base_now;
    if (cmd.load_mix_l) mix_l <= mute ? acc_l : acc_l + scaled;
    if (cmd.finish) begin
      mix_left_out  <= mix_l;
      mix_right_out <= mute ? acc_r : acc_r + scaled;
    end
  end

endmodule

// File: rtl/core/stereo_sample_mixer_gain_ramp_unit.sv
// Stereo sample mixer with pan, accent and ramped level; top level.
// Depends on ssmgr_pkg, ssmgr_ctrl, ssmgr_datapath.
// The first frame of each chunk runs the longer multiplier schedule below.
// One shared multiplier: a new frame is taken only after the current one is written back.
// A finished result waits in the output register while the next frame is taken.
// Reset (rst, synchronous): registers to defaults, levels, gains and chunk count zero.
module stereo_sample_mixer_gain_ramp_unit #(
  parameter int CHUNK_FRAMES = ssmgr_pkg::CHUNK_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [ssmgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssmgr_pkg::CFG_DATA_W-1:0] cfg_data,
  // input beat
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             note_first,
  input  logic signed [15:0]               src_left,
  input  logic signed [15:0]               src_right,
  input  logic signed [31:0]               mix_left_in,
  input  logic signed [31:0]               mix_right_in,
  // output beat
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               mix_left_out,
  output logic signed [31:0]               mix_right_out
);

  // Controller walks the multiplier schedule:
  //   chunk start: base, left pan*base, left gain, right pan*base, right gain,
  //                left mix, right mix, writeback
  //   other frame: left mix, right mix, writeback
  // Each multiply lands in one product register read by the next step.
  ssmgr_pkg::cmd_t    cmd;
  ssmgr_pkg::status_t status;

  ssmgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath holds config, level ramp, gains and the output register.
  // Note start reloads levels on the accepting edge; ramp advance and
  // chunk count update at writeback.
  ssmgr_datapath #(
    .CHUNK_FRAMES (CHUNK_FRAMES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .note_first    (note_first),
    .src_left      (src_left),
    .src_right     (src_right),
    .mix_left_in   (mix_left_in),
    .mix_right_in  (mix_right_in),
    .mix_left_out  (mix_left_out),
    .mix_right_out (mix_right_out),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

// File: tb/tb_stereo_sample_mixer_gain_ramp_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stereo mixer with pan, accent and level ramp.
// Depends on ssmgr_pkg and stereo_sample_mixer_gain_ramp_unit.
module tb_stereo_sample_mixer_gain_ramp_unit;

  localparam int CHUNK_FRAMES  = ssmgr_pkg::CHUNK_FRAMES_DEF;
  localparam int RANDOM_FRAMES = 1800;
  localparam int SETTLE_CYCLES = 12;    // idle margin, longer than the chunk-start latency
  localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int REPORT_MAX    = 10;

  // play modes other than accented; accented comes from the package
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_MUTED  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  typedef struct {
    logic        first;
    logic [15:0] smp_l;
    logic [15:0] smp_r;
    logic [31:0] acc_l;
    logic [31:0] acc_r;
  } frame_t;

  typedef struct {
    logic [31:0] mix_l;
    logic [31:0] mix_r;
  } mix_pair_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [ssmgr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ssmgr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             note_first = 1'b0;
  logic signed [15:0]               src_left = '0;
  logic signed [15:0]               src_right = '0;
  logic signed [31:0]               mix_left_in = '0;
  logic signed [31:0]               mix_right_in = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [31:0]               mix_left_out;
  logic signed [31:0]               mix_right_out;

  stereo_sample_mixer_gain_ramp_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .note_first   (note_first),
    .src_left     (src_left),
    .src_right    (src_right),
    .mix_left_in  (mix_left_in),
    .mix_right_in (mix_right_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mix_left_out (mix_left_out),
    .mix_right_out(mix_right_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Frames waiting to be sent, and mixes the block owes us, oldest first.
  frame_t    frame_q[$];
  mix_pair_t mix_expect_q[$];

  int  errors = 0;
  int  beats_out = 0;
  bit  quiet = 1'b0;  // set for the closing phase: no idling on either side

  // ---------------------------------------------------------------------
  // Mixer prediction: register copy, level/gain state, per-frame update
  // ---------------------------------------------------------------------
  logic [1:0]  cfg_mode   = MODE_NORMAL;
  logic [8:0]  cfg_base   = 9'd128;
  logic [9:0]  cfg_accent = 10'd384;
  logic [8:0]  cfg_pan    = 9'd128;
  logic [24:0] cfg_lstart = '0;
  logic [17:0] cfg_lstep  = '0;
  logic [24:0] cfg_rstart = '0;
  logic [17:0] cfg_rstep  = '0;

  int unsigned chunk_pos = 0;
  logic [31:0] lvl_l = '0;   // 16.16 external levels
  logic [31:0] lvl_r = '0;
  logic [11:0] gain_l = '0;
  logic [11:0] gain_r = '0;

  function automatic logic [11:0] gain_of(int unsigned pan_part, int unsigned base,
                                          logic [31:0] lvl);
    longint unsigned g;
    g = pan_part;
    g = (g * base * lvl[31:16]) >> 15;
    return (g > 4095) ? 12'd4095 : g[11:0];
  endfunction

  // Low 32 bits of sample * gain, arithmetic shift by 8, wrapping add.
  function automatic logic [31:0] scale_add(logic [31:0] acc, logic [15:0] smp,
                                            logic [11:0] g);
    logic [31:0] p;
    p = {{16{smp[15]}}, smp} * {20'd0, g};
    return acc + {{8{p[31]}}, p[31:8]};
  endfunction

  task automatic mixer_predict(input frame_t f);
    mix_pair_t   res;
    int unsigned lvl;
    int unsigned pan;
    int unsigned base;
    res.mix_l = f.acc_l;
    res.mix_r = f.acc_r;
    if (f.first) begin
      lvl_l = {7'd0, cfg_lstart};
      lvl_r = {7'd0, cfg_rstart};
      chunk_pos = 0;
    end
    // gains are only refreshed on the first frame of a chunk
    if (chunk_pos == 0) begin
      lvl  = (cfg_base > ssmgr_pkg::LEVEL_MAX) ? ssmgr_pkg::LEVEL_MAX : cfg_base;
      pan  = (cfg_pan > ssmgr_pkg::LEVEL_MAX) ? ssmgr_pkg::LEVEL_MAX : cfg_pan;
      base = (cfg_mode == ssmgr_pkg::MODE_ACCENT) ? ((cfg_accent * lvl) >> 8) : lvl;
      if (lvl_l[31]) lvl_l = '0;
      if (lvl_r[31]) lvl_r = '0;
      gain_l = gain_of(256 - pan, base, lvl_l);
      gain_r = gain_of(pan, base, lvl_r);
    end
    if (cfg_mode != MODE_MUTED && cfg_mode != MODE_SPARE) begin
      res.mix_l = scale_add(f.acc_l, f.smp_l, gain_l);
      res.mix_r = scale_add(f.acc_r, f.smp_r, gain_r);
    end
    chunk_pos++;
    if (chunk_pos >= CHUNK_FRAMES) begin
      chunk_pos = 0;
      lvl_l = lvl_l + {{14{cfg_lstep[17]}}, cfg_lstep} * 32'(CHUNK_FRAMES);
      lvl_r = lvl_r + {{14{cfg_rstep[17]}}, cfg_rstep} * 32'(CHUNK_FRAMES);
    end
    mix_expect_q.push_back(res);
  endtask

  // ---------------------------------------------------------------------
  // Input driver: pulls frames from frame_q, random gaps between beats
  // ---------------------------------------------------------------------
  frame_t cur_frame;
  int     send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // the held frame goes in at this edge: predict it now
      if (in_valid && in_ready) mixer_predict(cur_frame);
      if (!in_valid || in_ready) begin
        if (send_gap > 0 || frame_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          cur_frame = frame_q.pop_front();
          in_valid     <= 1'b1;
          note_first   <= cur_frame.first;
          src_left     <= cur_frame.smp_l;
          src_right    <= cur_frame.smp_r;
          mix_left_in  <= cur_frame.acc_l;
          mix_right_in <= cur_frame.acc_r;
          if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor: random backpressure, in-order field compare
  // ---------------------------------------------------------------------
  int        recv_stall = 0;
  mix_pair_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (mix_expect_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected beat %0d: left %h right %h", $time, beats_out,
                     mix_left_out, mix_right_out);
        end else begin
          want = mix_expect_q.pop_front();
          if (mix_left_out !== want.mix_l || mix_right_out !== want.mix_r) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: beat %0d mismatch: left exp %h got %h, right exp %h got %h",
                       $time, beats_out, want.mix_l, mix_left_out, want.mix_r,
                       mix_right_out);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 18);
      end
    end
  end

  // Watchdog: a long stretch with no beat on either side means a hang.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("stereo_sample_mixer_gain_ramp_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Register write; the model copy is updated at once since the block is idle.
  task automatic write_reg(input logic [ssmgr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [24:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      ssmgr_pkg::REG_PLAY_MODE:   cfg_mode   = val[1:0];
      ssmgr_pkg::REG_BASE_LEVEL:  cfg_base   = val[8:0];
      ssmgr_pkg::REG_ACCENT:      cfg_accent = val[9:0];
      ssmgr_pkg::REG_PAN:         cfg_pan    = val[8:0];
      ssmgr_pkg::REG_LEFT_START:  cfg_lstart = val[24:0];
      ssmgr_pkg::REG_LEFT_STEP:   cfg_lstep  = val[17:0];
      ssmgr_pkg::REG_RIGHT_START: cfg_rstart = val[24:0];
      ssmgr_pkg::REG_RIGHT_STEP:  cfg_rstep  = val[17:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every frame went in and every mix came back, then let the
  // pipeline settle before the next register write.
  task automatic drain();
    do @(posedge clk);
    while (frame_q.size() != 0 || in_valid || mix_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_frame(input logic first, input logic [15:0] sl, input logic [15:0] sr,
                             input logic [31:0] ml, input logic [31:0] mr);
    frame_t f;
    f.first = first;
    f.smp_l = sl;
    f.smp_r = sr;
    f.acc_l = ml;
    f.acc_r = mr;
    frame_q.push_back(f);
  endtask

  // Either extreme, or a random value; random ones sometimes carry junk above
  // the register width, which the block must drop.
  function automatic logic [24:0] pick_value(logic [24:0] lo, logic [24:0] hi, int w);
    logic [24:0] mask;
    logic [24:0] v;
    mask = (w >= 25) ? '1 : ((25'd1 << w) - 25'd1);
    v = 25'($urandom);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      2: return v;
      default: return v & mask;
    endcase
  endfunction

  task automatic shuffle_settings();
    write_reg(ssmgr_pkg::REG_PLAY_MODE,
              pick_value(25'(MODE_NORMAL), 25'(MODE_SPARE), 2));
    write_reg(ssmgr_pkg::REG_BASE_LEVEL,  pick_value(25'd0, 25'd256, 9));
    write_reg(ssmgr_pkg::REG_ACCENT,      pick_value(25'd0, 25'd1023, 10));
    write_reg(ssmgr_pkg::REG_PAN,         pick_value(25'd0, 25'd256, 9));
    write_reg(ssmgr_pkg::REG_LEFT_START,  pick_value(25'd0, 25'h1FFFFFF, 25));
    write_reg(ssmgr_pkg::REG_LEFT_STEP,   pick_value(25'h10000, 25'h30000, 18));  // +1.0, -1.0
    write_reg(ssmgr_pkg::REG_RIGHT_START, pick_value(25'd0, 25'h1FFFFFF, 25));
    write_reg(ssmgr_pkg::REG_RIGHT_STEP,  pick_value(25'h1FFFF, 25'h20000, 18));  // full span
    close_writes();
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_acc();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int sent;
    int span;
    int n;
    int len;
    int k;
    bit broken;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // No note started since reset: levels and gains are zero, mix passes through.
    queue_frame(1'b0, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_frame(1'b0, 16'h8000, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();

    // Full left pan, top base and start levels; accumulators wrap at the extremes.
    write_reg(ssmgr_pkg::REG_PLAY_MODE,   25'(MODE_NORMAL));
    write_reg(ssmgr_pkg::REG_BASE_LEVEL,  25'd256);
    write_reg(ssmgr_pkg::REG_ACCENT,      25'd1023);
    write_reg(ssmgr_pkg::REG_PAN,         25'd0);
    write_reg(ssmgr_pkg::REG_LEFT_START,  25'h1FFFFFF);
    write_reg(ssmgr_pkg::REG_LEFT_STEP,   25'd0);
    write_reg(ssmgr_pkg::REG_RIGHT_START, 25'h1FFFFFF);
    write_reg(ssmgr_pkg::REG_RIGHT_STEP,  25'd0);
    close_writes();
    queue_frame(1'b1, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_frame(1'b0, 16'h8000, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_frame(1'b0, 16'hFFFF, 16'h0001, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_frame(1'b0, 16'h0000, 16'h0000, 32'h1234_5678, 32'h8765_4321);
    drain();

    // Accented, pan and base above 256 saturate; right gain near its top.
    write_reg(ssmgr_pkg::REG_PLAY_MODE,  25'(ssmgr_pkg::MODE_ACCENT));
    write_reg(ssmgr_pkg::REG_BASE_LEVEL, 25'd511);
    write_reg(ssmgr_pkg::REG_PAN,        25'd511);
    close_writes();
    queue_frame(1'b1, 16'h7FFF, 16'h7FFF, 32'h7FFF_0000, 32'h7FFF_0000);
    queue_frame(1'b0, 16'h8000, 16'h8000, 32'h8000_FFFF, 32'h8000_FFFF);
    queue_frame(1'b1, 16'h5A5A, 16'hA5A5, 32'hFFFF_FFFF, 32'h0000_0001);
    drain();

    // Muted and the spare mode code both pass the mix through.
    write_reg(ssmgr_pkg::REG_PLAY_MODE, 25'(MODE_MUTED));
    close_writes();
    queue_frame(1'b1, 16'h7FFF, 16'h8000, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    queue_frame(1'b0, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    write_reg(ssmgr_pkg::REG_PLAY_MODE, 25'(MODE_SPARE));
    close_writes();
    queue_frame(1'b0, 16'h1234, 16'hFEDC, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_frame(1'b1, 16'h7FFF, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();

    // Random notes. The first phase is hot: the left level ramps up until the
    // gain saturates, the right one ramps below zero and gets clamped.
    // Each phase ends in a full drain, so the sender waits for every result.
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      if (sent == 0) begin
        write_reg(ssmgr_pkg::REG_PLAY_MODE,   25'(ssmgr_pkg::MODE_ACCENT));
        write_reg(ssmgr_pkg::REG_BASE_LEVEL,  25'd511);
        write_reg(ssmgr_pkg::REG_ACCENT,      25'd1023);
        write_reg(ssmgr_pkg::REG_PAN,         25'd64);
        write_reg(ssmgr_pkg::REG_LEFT_START,  25'h1FFFFFF);
        write_reg(ssmgr_pkg::REG_LEFT_STEP,   25'h1FFFF);
        write_reg(ssmgr_pkg::REG_RIGHT_START, 25'h10000);
        write_reg(ssmgr_pkg::REG_RIGHT_STEP,  25'h20000);
        close_writes();
      end else begin
        shuffle_settings();
      end
      span = $urandom_range(200, 320);
      if (RANDOM_FRAMES - sent <= 320) begin
        span  = RANDOM_FRAMES - sent;
        quiet = 1'b1;
      end
      n = 0;
      while (n < span) begin
        // mostly short notes, some long enough to cross chunk boundaries
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(257, 600) : $urandom_range(1, 60);
        broken = ($urandom_range(0, 9) == 0);
        for (k = 0; k < len && n < span; k++) begin
          queue_frame((k == 0) ? !broken : ($urandom_range(0, 49) == 0),
                      rand_sample(), rand_sample(), rand_acc(), rand_acc());
          n++;
        end
      end
      sent += span;
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && mix_expect_q.size() == 0) begin
      $display("stereo_sample_mixer_gain_ramp_unit regression: pass");
    end else begin
      $display("stereo_sample_mixer_gain_ramp_unit regression: fail");
    end
    $finish;
  end

endmodule
